// ===== rtl/scp_pkg.sv =====
// Shared types and constants for the segment closest-points block
package scp_pkg;

   localparam int DATA_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int QUO_BITS  = FRAC_BITS + 1;
   localparam int LIMB_BITS = 32;
   localparam int MUL_LAT   = 2;
   localparam int DIV_LAT   = QUO_BITS + 2;

   localparam logic [QUO_BITS-1:0] ONE_Q = QUO_BITS'(1) << FRAC_BITS;

   typedef struct packed {
      logic signed [DATA_BITS-1:0] start_a_x;
      logic signed [DATA_BITS-1:0] start_a_y;
      logic signed [DATA_BITS-1:0] start_a_z;
      logic signed [DATA_BITS-1:0] edge_a_x;
      logic signed [DATA_BITS-1:0] edge_a_y;
      logic signed [DATA_BITS-1:0] edge_a_z;
      logic signed [DATA_BITS-1:0] start_b_x;
      logic signed [DATA_BITS-1:0] start_b_y;
      logic signed [DATA_BITS-1:0] start_b_z;
      logic signed [DATA_BITS-1:0] edge_b_x;
      logic signed [DATA_BITS-1:0] edge_b_y;
      logic signed [DATA_BITS-1:0] edge_b_z;
   } req_word_type;

   typedef struct packed {
      logic signed [DATA_BITS-1:0] closest_a_x;
      logic signed [DATA_BITS-1:0] closest_a_y;
      logic signed [DATA_BITS-1:0] closest_a_z;
      logic signed [DATA_BITS-1:0] closest_b_x;
      logic signed [DATA_BITS-1:0] closest_b_y;
      logic signed [DATA_BITS-1:0] closest_b_z;
   } rsp_word_type;

endpackage

// ===== rtl/scp_req_if.sv =====
// Request channel: valid/ready handshake carrying one segment pair word
interface scp_req_if;
   logic                 valid;
   logic                 ready;
   scp_pkg::req_word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/scp_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one closest-points word
interface scp_rsp_if;
   logic                 valid;
   logic                 ready;
   scp_pkg::rsp_word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/scp_mul.sv =====
// Two-stage signed multiplier built from 33x33 limb products
module scp_mul #(
   parameter int AW = 32,
   parameter int BW = 32
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [AW-1:0]  a,
   input  logic signed [BW-1:0]  b,
   output logic signed [AW+BW-1:0] p
);
   localparam int LB = scp_pkg::LIMB_BITS;
   localparam int NA = (AW + LB - 1) / LB;
   localparam int NB = (BW + LB - 1) / LB;
   localparam int PW = AW + BW;
   localparam int EW = PW + 2 * LB + 2;

   logic signed [NA*LB-1:0] a_ext;
   logic signed [NB*LB-1:0] b_ext;
   logic signed [LB:0]      a_limb [NA];
   logic signed [LB:0]      b_limb [NB];
   logic signed [2*LB+1:0]  pp_in [NA][NB];
   logic signed [2*LB+1:0]  pp_ff [NA][NB];
   logic signed [PW-1:0]    sum_in;
   logic signed [PW-1:0]    p_ff;

   // split into limbs: low limbs unsigned, top limb carries the sign
   always_comb begin
      a_ext = (NA*LB)'(a);
      b_ext = (NB*LB)'(b);
      for (int i = 0; i < NA; i++) begin
         if (i == NA - 1) begin
            a_limb[i] = {a_ext[NA*LB-1], a_ext[i*LB +: LB]};
         end else begin
            a_limb[i] = {1'b0, a_ext[i*LB +: LB]};
         end
      end
      for (int j = 0; j < NB; j++) begin
         if (j == NB - 1) begin
            b_limb[j] = {b_ext[NB*LB-1], b_ext[j*LB +: LB]};
         end else begin
            b_limb[j] = {1'b0, b_ext[j*LB +: LB]};
         end
      end
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            pp_in[i][j] = a_limb[i] * b_limb[j];
         end
      end
   end

   // align and add the limb products
   always_comb begin
      logic signed [EW-1:0] term;
      sum_in = '0;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            term   = EW'(pp_ff[i][j]);
            term   = term <<< (LB * (i + j));
            sum_in = sum_in + term[PW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
               pp_ff[i][j] <= pp_in[i][j];
            end
         end
         p_ff <= sum_in;
      end
   end

   assign p = p_ff;

endmodule

// ===== rtl/scp_div.sv =====
// Pipelined signed divider, one quotient bit per stage, result clamped to [0, 1.0]
module scp_div #(
   parameter int NW = 48,
   parameter int DW = 32
) (
   input  logic                           clock,
   input  logic                           en,
   input  logic signed [NW-1:0]           num,
   input  logic signed [DW-1:0]           den,
   output logic [scp_pkg::QUO_BITS-1:0]   quo,
   output logic                           den_zero,
   output logic                           neg,
   output logic                           over
);
   localparam int QB = scp_pkg::QUO_BITS;
   localparam int RW = ((NW > DW + QB) ? NW : DW + QB) + 1;

   logic [NW-1:0]  nmag_in, nmag_ff;
   logic [DW-1:0]  dmag_in, dmag_ff;
   logic           diff_in, diff_ff;
   logic           dz_in, dz_ff;

   logic [RW-1:0]  rem_in [QB];
   logic [RW-1:0]  rem_ff [QB];
   logic [DW-1:0]  dm_in  [QB];
   logic [DW-1:0]  dm_ff  [QB];
   logic [QB-1:0]  quo_in [QB+1];
   logic [QB-1:0]  quo_ff [QB+1];
   logic           sgn_in [QB+1];
   logic           sgn_ff [QB+1];
   logic           zr_in  [QB+1];
   logic           zr_ff  [QB+1];
   logic           big_in [QB+1];
   logic           big_ff [QB+1];

   logic [QB-1:0]  q_fin;
   logic           nonzero;

   // take magnitudes and signs
   always_comb begin
      nmag_in = num[NW-1] ? (~num + 1'b1) : num;
      dmag_in = den[DW-1] ? (~den + 1'b1) : den;
      diff_in = num[NW-1] ^ den[DW-1];
      dz_in   = (den == '0);
   end

   // overflow check, then one restoring step per stage
   always_comb begin
      logic [RW-1:0] trial;
      rem_in[0] = RW'(nmag_ff);
      dm_in[0]  = dmag_ff;
      quo_in[0] = '0;
      sgn_in[0] = diff_ff;
      zr_in[0]  = dz_ff;
      big_in[0] = RW'(nmag_ff) >= (RW'(dmag_ff) << QB);
      for (int j = 0; j < QB; j++) begin
         trial       = RW'(dm_ff[j]) << (QB - 1 - j);
         quo_in[j+1] = quo_ff[j];
         if (j + 1 < QB) begin
            rem_in[j+1] = rem_ff[j];
            dm_in[j+1]  = dm_ff[j];
         end
         if (rem_ff[j] >= trial) begin
            quo_in[j+1] = quo_ff[j] | (QB'(1) << (QB - 1 - j));
            if (j + 1 < QB) begin
               rem_in[j+1] = rem_ff[j] - trial;
            end
         end
         sgn_in[j+1] = sgn_ff[j];
         zr_in[j+1]  = zr_ff[j];
         big_in[j+1] = big_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nmag_ff <= nmag_in;
         dmag_ff <= dmag_in;
         diff_ff <= diff_in;
         dz_ff   <= dz_in;
         for (int j = 0; j < QB; j++) begin
            rem_ff[j] <= rem_in[j];
            dm_ff[j]  <= dm_in[j];
         end
         for (int j = 0; j <= QB; j++) begin
            quo_ff[j] <= quo_in[j];
            sgn_ff[j] <= sgn_in[j];
            zr_ff[j]  <= zr_in[j];
            big_ff[j] <= big_in[j];
         end
      end
   end

   // classify the truncated quotient and clamp it
   always_comb begin
      q_fin    = quo_ff[QB];
      nonzero  = big_ff[QB] || (q_fin != '0);
      neg      = sgn_ff[QB] && nonzero;
      over     = !sgn_ff[QB] && (big_ff[QB] || (q_fin > scp_pkg::ONE_Q));
      den_zero = zr_ff[QB];
      if (neg) begin
         quo = '0;
      end else if (over) begin
         quo = scp_pkg::ONE_Q;
      end else begin
         quo = q_fin;
      end
   end

endmodule

// ===== rtl/segment_closest_points.sv =====
// Closest points between two 3D segments, fully pipelined
//
//   channel   dir   word                     handshake
//   req_chan  in    two segments, Q16.16     valid/ready
//   rsp_chan  out   two closest points       valid/ready
//
// Each accepted word yields its result word, in order; one word is taken every
// cycle while the output word is not held. The depth is set by two 19-stage quotient
// dividers in series (t, then u) and the limb-product multipliers around them. Reset
// clears only the valid bits. When the output word is held and not taken, every stage
// freezes together and nothing is dropped or repeated.
module segment_closest_points #(
   parameter int COORD_BITS = 32
) (
   input  logic          clock,
   input  logic          reset,
   scp_req_if.sink       req_chan,
   scp_rsp_if.source     rsp_chan
);
   localparam int W    = COORD_BITS;
   localparam int FB   = scp_pkg::FRAC_BITS;
   localparam int QB   = scp_pkg::QUO_BITS;
   localparam int DB   = scp_pkg::DATA_BITS;
   localparam int DOTW = 2 * W + 3;
   localparam int PW   = 2 * DOTW + 1;
   localparam int UNW  = DOTW + QB + 2;

   // stage numbers, counted from the input register
   localparam int ST_IN  = 1;
   localparam int ST_DOT = ST_IN + scp_pkg::MUL_LAT + 1;
   localparam int ST_DET = ST_DOT + scp_pkg::MUL_LAT + 1;
   localparam int ST_T0  = ST_DET + scp_pkg::DIV_LAT;
   localparam int ST_UN  = ST_T0 + scp_pkg::MUL_LAT + 1;
   localparam int ST_U   = ST_UN + scp_pkg::DIV_LAT;
   localparam int ST_OUT = ST_U + scp_pkg::MUL_LAT + 1;

   localparam int PD     = ST_OUT - 1;
   localparam int D_DET  = ST_DET - ST_DOT;
   localparam int D_AB   = ST_T0 - ST_DOT;
   localparam int D_BT   = ST_UN - 1 - ST_DOT;
   localparam int D_BB   = ST_UN - ST_DOT;
   localparam int D_SEL  = ST_U - ST_T0;

   logic adv;
   logic vld_ff [ST_OUT];

   logic signed [W-1:0] sa_in [3], ea_in [3], sb_in [3], eb_in [3];
   logic signed [W:0]   dv_in [3], dv_ff [3];
   logic signed [W-1:0] sa_ff [PD][3], ea_ff [PD][3], sb_ff [PD][3], eb_ff [PD][3];

   logic signed [2*W-1:0] p_aa [3], p_bb [3], p_ab [3];
   logic signed [2*W:0]   p_at [3], p_bt [3];

   logic signed [DOTW-1:0] aa_in, bb_in, ab_in, at_in, bt_in, abat_in;
   logic signed [DOTW-1:0] aa_ff, bb_ff, ab_ff, at_ff, bt_ff, abat_ff;
   logic signed [DOTW-1:0] aa_dly [D_DET], at_dly [D_DET], abat_dly [D_DET];
   logic signed [DOTW-1:0] ab_dly [D_AB], bt_dly [D_BT], bb_dly [D_BB];

   logic signed [2*DOTW-1:0] p_aabb, p_abab, p_atbb, p_btab;
   logic signed [PW-1:0]     det_in, det_ff, nm_in, nm_ff;

   logic [QB-1:0] t0_quo, tlo_quo, thi_quo, u_quo;
   logic          t0_dz, tlo_dz, thi_dz, u_dz, u_neg, u_over;
   logic [QB-1:0] t0c, tloc, thic;
   logic [QB-1:0] t0_dly [D_SEL], tlo_dly [D_SEL], thi_dly [D_SEL];

   logic signed [QB+DOTW:0] p_ut;
   logic signed [UNW-1:0]   unum_in, unum_ff;

   logic [QB-1:0] tsel, usel;
   logic signed [W+QB:0] p_pa [3], p_pb [3];

   logic signed [W-1:0]    ca [3], cb [3];
   scp_pkg::rsp_word_type  out_in, out_ff;

   function automatic logic signed [W-1:0] sat_coord(input logic signed [W+2:0] v);
      logic [3:0] top;
      top = v[W+2:W-1];
      if (top == '0 || top == '1) begin
         return v[W-1:0];
      end else if (v[W+2]) begin
         return {1'b1, {(W-1){1'b0}}};
      end else begin
         return {1'b0, {(W-1){1'b1}}};
      end
   endfunction

   // advance the whole pipe unless the output word is held
   assign adv            = !vld_ff[ST_OUT-1] || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign rsp_chan.valid = vld_ff[ST_OUT-1];
   assign rsp_chan.data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ST_OUT; i++) vld_ff[i] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_chan.valid;
         for (int i = 1; i < ST_OUT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // narrow the incoming coordinates and form the start offset
   always_comb begin
      sa_in[0] = req_chan.data.start_a_x[W-1:0];
      sa_in[1] = req_chan.data.start_a_y[W-1:0];
      sa_in[2] = req_chan.data.start_a_z[W-1:0];
      ea_in[0] = req_chan.data.edge_a_x[W-1:0];
      ea_in[1] = req_chan.data.edge_a_y[W-1:0];
      ea_in[2] = req_chan.data.edge_a_z[W-1:0];
      sb_in[0] = req_chan.data.start_b_x[W-1:0];
      sb_in[1] = req_chan.data.start_b_y[W-1:0];
      sb_in[2] = req_chan.data.start_b_z[W-1:0];
      eb_in[0] = req_chan.data.edge_b_x[W-1:0];
      eb_in[1] = req_chan.data.edge_b_y[W-1:0];
      eb_in[2] = req_chan.data.edge_b_z[W-1:0];
      for (int k = 0; k < 3; k++) begin
         dv_in[k] = (W+1)'(sb_in[k]) - (W+1)'(sa_in[k]);
      end
   end

   // carry the endpoints down to the output stages
   always_ff @(posedge clock) begin
      if (adv) begin
         sa_ff[0] <= sa_in;
         ea_ff[0] <= ea_in;
         sb_ff[0] <= sb_in;
         eb_ff[0] <= eb_in;
         dv_ff    <= dv_in;
         for (int i = 1; i < PD; i++) begin
            sa_ff[i] <= sa_ff[i-1];
            ea_ff[i] <= ea_ff[i-1];
            sb_ff[i] <= sb_ff[i-1];
            eb_ff[i] <= eb_ff[i-1];
         end
      end
   end

   // per-axis products for the five dot products
   for (genvar k = 0; k < 3; k++) begin : g_dot
      scp_mul #(.AW(W), .BW(W)) u_aa (
         .clock(clock), .en(adv), .a(ea_ff[0][k]), .b(ea_ff[0][k]), .p(p_aa[k]));
      scp_mul #(.AW(W), .BW(W)) u_bb (
         .clock(clock), .en(adv), .a(eb_ff[0][k]), .b(eb_ff[0][k]), .p(p_bb[k]));
      scp_mul #(.AW(W), .BW(W)) u_ab (
         .clock(clock), .en(adv), .a(ea_ff[0][k]), .b(eb_ff[0][k]), .p(p_ab[k]));
      scp_mul #(.AW(W), .BW(W + 1)) u_at (
         .clock(clock), .en(adv), .a(ea_ff[0][k]), .b(dv_ff[k]), .p(p_at[k]));
      scp_mul #(.AW(W), .BW(W + 1)) u_bt (
         .clock(clock), .en(adv), .a(eb_ff[0][k]), .b(dv_ff[k]), .p(p_bt[k]));
   end

   // sum the axes
   always_comb begin
      aa_in   = DOTW'(p_aa[0]) + DOTW'(p_aa[1]) + DOTW'(p_aa[2]);
      bb_in   = DOTW'(p_bb[0]) + DOTW'(p_bb[1]) + DOTW'(p_bb[2]);
      ab_in   = DOTW'(p_ab[0]) + DOTW'(p_ab[1]) + DOTW'(p_ab[2]);
      at_in   = DOTW'(p_at[0]) + DOTW'(p_at[1]) + DOTW'(p_at[2]);
      bt_in   = DOTW'(p_bt[0]) + DOTW'(p_bt[1]) + DOTW'(p_bt[2]);
      abat_in = ab_in + at_in;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         aa_ff   <= aa_in;
         bb_ff   <= bb_in;
         ab_ff   <= ab_in;
         at_ff   <= at_in;
         bt_ff   <= bt_in;
         abat_ff <= abat_in;
      end
   end

   // hold dot products until their consumers come up
   always_ff @(posedge clock) begin
      if (adv) begin
         aa_dly[0]   <= aa_ff;
         at_dly[0]   <= at_ff;
         abat_dly[0] <= abat_ff;
         ab_dly[0]   <= ab_ff;
         bt_dly[0]   <= bt_ff;
         bb_dly[0]   <= bb_ff;
         for (int i = 1; i < D_DET; i++) begin
            aa_dly[i]   <= aa_dly[i-1];
            at_dly[i]   <= at_dly[i-1];
            abat_dly[i] <= abat_dly[i-1];
         end
         for (int i = 1; i < D_AB; i++) ab_dly[i] <= ab_dly[i-1];
         for (int i = 1; i < D_BT; i++) bt_dly[i] <= bt_dly[i-1];
         for (int i = 1; i < D_BB; i++) bb_dly[i] <= bb_dly[i-1];
      end
   end

   // determinant and numerator of t
   scp_mul #(.AW(DOTW), .BW(DOTW)) u_aabb (
      .clock(clock), .en(adv), .a(aa_ff), .b(bb_ff), .p(p_aabb));
   scp_mul #(.AW(DOTW), .BW(DOTW)) u_abab (
      .clock(clock), .en(adv), .a(ab_ff), .b(ab_ff), .p(p_abab));
   scp_mul #(.AW(DOTW), .BW(DOTW)) u_atbb (
      .clock(clock), .en(adv), .a(at_ff), .b(bb_ff), .p(p_atbb));
   scp_mul #(.AW(DOTW), .BW(DOTW)) u_btab (
      .clock(clock), .en(adv), .a(bt_ff), .b(ab_ff), .p(p_btab));

   assign det_in = PW'(p_aabb) - PW'(p_abab);
   assign nm_in  = PW'(p_atbb) - PW'(p_btab);

   always_ff @(posedge clock) begin
      if (adv) begin
         det_ff <= det_in;
         nm_ff  <= nm_in;
      end
   end

   // t0 and the two fallback values of t, all in parallel
   scp_div #(.NW(PW + FB), .DW(PW)) u_div_t0 (
      .clock(clock), .en(adv), .num($signed({nm_ff, {FB{1'b0}}})), .den(det_ff),
      .quo(t0_quo), .den_zero(t0_dz), .neg(), .over());
   scp_div #(.NW(DOTW + FB), .DW(DOTW)) u_div_tlo (
      .clock(clock), .en(adv), .num($signed({at_dly[D_DET-1], {FB{1'b0}}})),
      .den(aa_dly[D_DET-1]), .quo(tlo_quo), .den_zero(tlo_dz), .neg(), .over());
   scp_div #(.NW(DOTW + FB), .DW(DOTW)) u_div_thi (
      .clock(clock), .en(adv), .num($signed({abat_dly[D_DET-1], {FB{1'b0}}})),
      .den(aa_dly[D_DET-1]), .quo(thi_quo), .den_zero(thi_dz), .neg(), .over());

   // a zero divisor forces t to zero
   assign t0c  = t0_dz  ? '0 : t0_quo;
   assign tloc = tlo_dz ? '0 : tlo_quo;
   assign thic = thi_dz ? '0 : thi_quo;

   always_ff @(posedge clock) begin
      if (adv) begin
         t0_dly[0]  <= t0c;
         tlo_dly[0] <= tloc;
         thi_dly[0] <= thic;
         for (int i = 1; i < D_SEL; i++) begin
            t0_dly[i]  <= t0_dly[i-1];
            tlo_dly[i] <= tlo_dly[i-1];
            thi_dly[i] <= thi_dly[i-1];
         end
      end
   end

   // numerator of u: t0*AB - BT*1.0
   scp_mul #(.AW(QB + 1), .BW(DOTW)) u_ut (
      .clock(clock), .en(adv), .a($signed({1'b0, t0c})), .b(ab_dly[D_AB-1]), .p(p_ut));

   assign unum_in = UNW'(p_ut) - UNW'($signed({bt_dly[D_BT-1], {FB{1'b0}}}));

   always_ff @(posedge clock) begin
      if (adv) begin
         unum_ff <= unum_in;
      end
   end

   scp_div #(.NW(UNW), .DW(DOTW)) u_div_u (
      .clock(clock), .en(adv), .num(unum_ff), .den(bb_dly[D_BB-1]),
      .quo(u_quo), .den_zero(u_dz), .neg(u_neg), .over(u_over));

   // pick t and u: clamp u at either end and fall back to the matching t
   always_comb begin
      if (u_dz || u_neg) begin
         usel = '0;
         tsel = tlo_dly[D_SEL-1];
      end else if (u_over) begin
         usel = scp_pkg::ONE_Q;
         tsel = thi_dly[D_SEL-1];
      end else begin
         usel = u_quo;
         tsel = t0_dly[D_SEL-1];
      end
   end

   // scale the edges by t and u
   for (genvar k = 0; k < 3; k++) begin : g_pt
      scp_mul #(.AW(W), .BW(QB + 1)) u_pa (
         .clock(clock), .en(adv), .a(ea_ff[ST_U-1][k]), .b($signed({1'b0, tsel})),
         .p(p_pa[k]));
      scp_mul #(.AW(W), .BW(QB + 1)) u_pb (
         .clock(clock), .en(adv), .a(eb_ff[ST_U-1][k]), .b($signed({1'b0, usel})),
         .p(p_pb[k]));
   end

   // add to the start points, floor the fraction, saturate
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ca[k] = sat_coord((W+3)'(sa_ff[PD-1][k]) + (W+3)'(p_pa[k] >>> FB));
         cb[k] = sat_coord((W+3)'(sb_ff[PD-1][k]) + (W+3)'(p_pb[k] >>> FB));
      end
      out_in.closest_a_x = DB'(ca[0]);
      out_in.closest_a_y = DB'(ca[1]);
      out_in.closest_a_z = DB'(ca[2]);
      out_in.closest_b_x = DB'(cb[0]);
      out_in.closest_b_y = DB'(cb[1]);
      out_in.closest_b_z = DB'(cb[2]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

endmodule

// ===== verif/tb_segment_closest_points.sv =====
// Testbench for segment_closest_points: directed and random segment pairs, checked field by field
`timescale 1ns / 100ps

module tb_segment_closest_points;

   typedef logic signed [191:0] acc_type;

   localparam longint UNIT_Q      = 65536;
   localparam int     CYCLE_LIMIT = 400000;
   localparam int     TAIL_CYCLES = 120;
   localparam int     RANDOM_ITEMS = 950;

   logic clock;
   logic reset;
   int   errors;
   int   cycles;
   bit   no_idle;

   scp_pkg::rsp_word_type closest_q[$];

   scp_req_if req_chan ();
   scp_rsp_if rsp_chan ();

   segment_closest_points u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   // run the clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // bound the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // limit a parameter to the unit interval
   function automatic longint unit_clamp(input acc_type v);
      if (v < 0) return 0;
      if (v > UNIT_Q) return UNIT_Q;
      return longint'(v);
   endfunction

   // start + floor(edge * param / 2^16), saturated to 32 bits
   function automatic logic signed [31:0] point_on(input logic signed [31:0] s,
                                                   input logic signed [31:0] e,
                                                   input longint prm);
      longint p;
      p = longint'(s) + ((longint'(e) * prm) >>> 16);
      if (p > 64'sd2147483647) p = 64'sd2147483647;
      if (p < -64'sd2147483648) p = -64'sd2147483648;
      return p[31:0];
   endfunction

   // closest points between the two segments
   function automatic scp_pkg::rsp_word_type closest_points(input scp_pkg::req_word_type w);
      acc_type ea[3], eb[3], dv[3];
      acc_type aa, bb, ab, at, bt, det, uq;
      longint tp, up;
      scp_pkg::rsp_word_type r;
      ea[0] = w.edge_a_x; ea[1] = w.edge_a_y; ea[2] = w.edge_a_z;
      eb[0] = w.edge_b_x; eb[1] = w.edge_b_y; eb[2] = w.edge_b_z;
      dv[0] = acc_type'(w.start_b_x) - acc_type'(w.start_a_x);
      dv[1] = acc_type'(w.start_b_y) - acc_type'(w.start_a_y);
      dv[2] = acc_type'(w.start_b_z) - acc_type'(w.start_a_z);
      aa = 0; bb = 0; ab = 0; at = 0; bt = 0;
      for (int i = 0; i < 3; i++) begin
         aa += ea[i] * ea[i];
         bb += eb[i] * eb[i];
         ab += ea[i] * eb[i];
         at += ea[i] * dv[i];
         bt += eb[i] * dv[i];
      end
      det = aa * bb - ab * ab;
      tp = 0;
      if (det != 0) tp = unit_clamp(((at * bb - bt * ab) <<< 16) / det);
      // solve u; when it leaves the unit interval, clamp it and solve t again
      up = 0;
      if (bb != 0) begin
         uq = (acc_type'(tp) * ab - (bt <<< 16)) / bb;
         if (uq < 0) begin
            tp = (aa != 0) ? unit_clamp((at <<< 16) / aa) : 0;
         end else if (uq > UNIT_Q) begin
            up = UNIT_Q;
            tp = (aa != 0) ? unit_clamp(((ab + at) <<< 16) / aa) : 0;
         end else begin
            up = longint'(uq);
         end
      end else begin
         tp = (aa != 0) ? unit_clamp((at <<< 16) / aa) : 0;
      end
      r.closest_a_x = point_on(w.start_a_x, w.edge_a_x, tp);
      r.closest_a_y = point_on(w.start_a_y, w.edge_a_y, tp);
      r.closest_a_z = point_on(w.start_a_z, w.edge_a_z, tp);
      r.closest_b_x = point_on(w.start_b_x, w.edge_b_x, up);
      r.closest_b_y = point_on(w.start_b_y, w.edge_b_y, up);
      r.closest_b_z = point_on(w.start_b_z, w.edge_b_z, up);
      return r;
   endfunction

   // compare each result word with the oldest expectation
   always @(posedge clock) begin
      scp_pkg::rsp_word_type want;
      scp_pkg::rsp_word_type got;
      string fname[6];
      fname = '{"closest_a_x", "closest_a_y", "closest_a_z",
                "closest_b_x", "closest_b_y", "closest_b_z"};
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.data;
         if (closest_q.size() == 0) begin
            errors++;
            $display("%0t: result word with none expected: %h", $realtime, got);
         end else begin
            want = closest_q.pop_front();
            for (int i = 0; i < 6; i++) begin
               if (got[32*(5-i) +: 32] !== want[32*(5-i) +: 32]) begin
                  errors++;
                  $display("%0t: %s expected %h actual %h", $realtime, fname[i],
                           want[32*(5-i) +: 32], got[32*(5-i) +: 32]);
               end
            end
         end
      end
   end

   // result side: stall a random number of cycles before each word
   initial begin
      int n;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         n = no_idle ? 0 : $urandom_range(0, 15);
         if (n > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         @(negedge clock);
      end
   end

   // send one word; called at a rising edge, returns at the edge that takes it
   task automatic send_pair(input scp_pkg::req_word_type w);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 15);
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= w;
      do @(posedge clock); while (!req_chan.ready);
      closest_q.insert(closest_q.size(), closest_points(w));
   endtask

   // hold the sender until every expected word has come back
   task automatic drain();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (closest_q.size() != 0) @(posedge clock);
   endtask

   function automatic scp_pkg::req_word_type pair_of(
         input int sax, input int say, input int saz,
         input int eax, input int eay, input int eaz,
         input int sbx, input int sby, input int sbz,
         input int ebx, input int eby, input int ebz);
      scp_pkg::req_word_type w;
      w = {sax, say, saz, eax, eay, eaz, sbx, sby, sbz, ebx, eby, ebz};
      return w;
   endfunction

   function automatic int rand_coord(input int span);
      if (span >= 31) return $urandom;
      return int'($urandom_range(0, (1 << (span + 1)) - 1)) - (1 << span);
   endfunction

   // crossing, clamping and out-of-range parameter cases
   task automatic test_geometry();
      localparam int Q = 65536;
      send_pair(pair_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_pair(pair_of(0, 0, 0, 2*Q, 0, 0, Q, -Q, Q, 0, 2*Q, 0));
      send_pair(pair_of(0, 0, 0, Q, 0, 0, 5*Q, Q, 0, 0, Q, 0));
      send_pair(pair_of(0, 0, 0, Q, 0, 0, -5*Q, -Q, 0, 0, Q, 0));
      // u below zero and above one
      send_pair(pair_of(0, 0, 0, Q, 0, 0, Q/2, 3*Q, Q, 0, Q, 0));
      send_pair(pair_of(0, 0, 0, Q, 0, 0, Q/2, -3*Q, Q, 0, Q, 0));
      send_pair(pair_of(Q, 2*Q, -Q, -Q, 3, Q/3, 7, -Q, 2*Q, Q+1, -Q, 5));
   endtask

   // parallel segments, zero-length segments
   task automatic test_degenerate();
      localparam int Q = 65536;
      send_pair(pair_of(0, 0, 0, Q, 0, 0, 0, Q, 0, 2*Q, 0, 0));
      send_pair(pair_of(0, 0, 0, Q, Q, 0, 3*Q, Q, Q, -Q, -Q, 0));
      send_pair(pair_of(0, 0, 0, 4*Q, 0, 0, Q, Q, 0, 0, 0, 0));
      send_pair(pair_of(Q, Q, Q, 0, 0, 0, 0, 0, 0, Q, 2*Q, 0));
      send_pair(pair_of(Q, -Q, Q, 0, 0, 0, -Q, Q, 3, 0, 0, 0));
      send_pair(pair_of(5, 5, 5, 0, 0, 0, 5, 5, 5, 0, 0, 0));
   endtask

   // field extremes and output saturation
   task automatic test_extremes();
      int mx, mn;
      mx = 32'h7fffffff;
      mn = 32'h80000000;
      send_pair(pair_of(mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx));
      send_pair(pair_of(mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn));
      send_pair(pair_of(mx, mn, 0, mx, mx, 0, 0, mx, 0, 0, 0, 0));
      send_pair(pair_of(mn, mx, 0, mn, mn, 0, 0, mn, 0, 0, 0, 0));
      send_pair(pair_of(mn, mn, mn, mx, mx, mx, mx, mx, mx, mn, mn, mn));
      send_pair(pair_of(mx, 0, mn, mn, 1, mx, mn, -1, mx, mx, -1, mn));
      send_pair(pair_of(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
   endtask

   // random pairs: mostly modest coordinates, some full width, some degenerate
   task automatic test_random(input int count);
      scp_pkg::req_word_type w;
      int span, kind, k;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(0, 9);
         span = (kind < 2) ? 31 : $urandom_range(12, 24);
         w = pair_of(rand_coord(span), rand_coord(span), rand_coord(span),
                     rand_coord(span), rand_coord(span), rand_coord(span),
                     rand_coord(span), rand_coord(span), rand_coord(span),
                     rand_coord(span), rand_coord(span), rand_coord(span));
         case (kind)
            2: begin
               k = $urandom_range(0, 6) - 3;
               w.edge_b_x = w.edge_a_x * k;
               w.edge_b_y = w.edge_a_y * k;
               w.edge_b_z = w.edge_a_z * k;
            end
            3: begin
               w.edge_b_x = 0; w.edge_b_y = 0; w.edge_b_z = 0;
            end
            4: begin
               w.edge_a_x = 0; w.edge_a_y = 0; w.edge_a_z = 0;
            end
            default: ;
         endcase
         send_pair(w);
      end
   endtask

   initial begin
      errors = 0;
      cycles = 0;
      no_idle = 1'b0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_geometry();
      test_degenerate();
      drain();
      test_extremes();
      test_random(RANDOM_ITEMS / 2);
      drain();
      // back-to-back stretch with no idling on either side
      no_idle = 1'b1;
      test_random(RANDOM_ITEMS / 4);
      no_idle = 1'b0;
      test_random(RANDOM_ITEMS / 4);

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
